/* hdl/assert_macros.svh */
// Assertion macros shared by the DMX slot window receiver RTL.
// No dependencies; taken in by `include where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is held.
`define DSW_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that also checks during reset.
`define DSW_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/dmxsw_pkg.sv */
// Types and constants for the DMX slot window receiver.
// No dependencies; used by dmxsw_window and dmx_slot_window_receiver.
`timescale 1ns / 1ps

package dmxsw_pkg;

    localparam int SLOT_W   = 10;
    localparam int OFFS_W   = 9;
    localparam int BYTE_W   = 8;
    localparam int DEV_W    = 2;
    localparam int CIDX_W   = 3;
    localparam int CDATA_W  = 10;
    localparam int DEV_MAX  = 3;

    localparam logic [CIDX_W-1:0] CFG_START_CODE = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_DEV0_FIRST = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_DEV0_COUNT = 3'd2;

    localparam logic [BYTE_W-1:0] START_CODE_RST = 8'd0;
    localparam logic [SLOT_W-1:0] FIRST_RST      = 10'd1;
    localparam logic [SLOT_W-1:0] COUNT_RST      = 10'd0;

    typedef struct packed {
        logic              hit;
        logic              last;
        logic [OFFS_W-1:0] offset;
    } t_win;

endpackage

/* hdl/dmxsw_window.sv */
// Slot window match for one device: hit, offset into the window, last slot.
// Depends on dmxsw_pkg.
`timescale 1ns / 1ps

module dmxsw_window (
    input  logic [dmxsw_pkg::SLOT_W-1:0] i_slot,
    input  logic [dmxsw_pkg::SLOT_W-1:0] i_first,
    input  logic [dmxsw_pkg::SLOT_W-1:0] i_count,
    output dmxsw_pkg::t_win              o_win
);

    logic [dmxsw_pkg::SLOT_W:0]   w_end;
    logic [dmxsw_pkg::SLOT_W:0]   w_next;
    logic [dmxsw_pkg::SLOT_W-1:0] w_diff;

    assign w_end  = {1'b0, i_first} + {1'b0, i_count};
    assign w_next = {1'b0, i_slot} + {{dmxsw_pkg::SLOT_W{1'b0}}, 1'b1};
    assign w_diff = i_slot - i_first;

    always_comb begin
        o_win.hit    = (i_count != '0) && (i_slot >= i_first) && ({1'b0, i_slot} < w_end);
        o_win.last   = (w_next == w_end);
        o_win.offset = w_diff[dmxsw_pkg::OFFS_W-1:0];
    end

endmodule

/* hdl/dmx_slot_window_receiver.sv */
// DMX512 slot window receiver top level: framing, slot counter, routing.
// Depends on dmxsw_pkg, dmxsw_window and assert_macros.svh.
//
// Input channel: one word per received byte or line break (i_is_break set).
// A word is taken at a clock edge with i_in_valid high and o_in_stall low.
// Output channel: one word per data slot that falls in a device window,
// carrying device index, offset in the window, the byte and a last-slot flag.
// The word is taken at an edge with o_out_valid high and i_out_stall low.
// Config channel: register index and data, written when i_cfg_valid and
// o_cfg_ready are high; o_cfg_ready is always high. Write only while idle.
// An input word lands in the input register; its result (if any) then moves
// through the window compare into the output register.
// Throughput: one word per cycle unless the output stalls, set by the single
// pass from input register through the window compare to the output register.
// A stall on the output holds both registers; o_in_stall rises when the
// input register is full and cannot move on.
// Reset: counter to zero, receiver online, start code 0, all windows empty.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dmx_slot_window_receiver #(
    parameter int MAX_SLOT    = 512,
    parameter int NUM_DEVICES = 3
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic                             i_is_break,
    input  logic [dmxsw_pkg::BYTE_W-1:0]     i_rx_byte,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [dmxsw_pkg::DEV_W-1:0]      o_device_index,
    output logic [dmxsw_pkg::OFFS_W-1:0]     o_slot_offset,
    output logic [dmxsw_pkg::BYTE_W-1:0]     o_slot_value,
    output logic                             o_window_done,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [dmxsw_pkg::CIDX_W-1:0]     i_cfg_index,
    input  logic [dmxsw_pkg::CDATA_W-1:0]    i_cfg_data
);

    localparam logic [dmxsw_pkg::SLOT_W-1:0] SLOT_MAX = dmxsw_pkg::SLOT_W'(MAX_SLOT);
    localparam logic [dmxsw_pkg::SLOT_W-1:0] SLOT_SAT = dmxsw_pkg::SLOT_W'(MAX_SLOT + 1);

    logic [dmxsw_pkg::BYTE_W-1:0] r_start_code;
    logic [dmxsw_pkg::SLOT_W-1:0] r_first [NUM_DEVICES];
    logic [dmxsw_pkg::SLOT_W-1:0] r_count [NUM_DEVICES];

    logic                         r_in_valid;
    logic                         r_in_brk;
    logic [dmxsw_pkg::BYTE_W-1:0] r_in_byte;

    logic [dmxsw_pkg::SLOT_W-1:0] r_slot, n_slot;
    logic                         r_off, n_off;

    logic                          r_out_valid;
    logic [dmxsw_pkg::DEV_W-1:0]   r_out_dev, n_out_dev;
    logic [dmxsw_pkg::OFFS_W-1:0]  r_out_offs, n_out_offs;
    logic [dmxsw_pkg::BYTE_W-1:0]  r_out_byte;
    logic                          r_out_last, n_out_last;
    logic                          n_out_hit;

    logic            w_adv;
    logic            w_take;
    dmxsw_pkg::t_win w_win [NUM_DEVICES];

    assign o_cfg_ready = 1'b1;
    assign w_adv       = !r_out_valid || !i_out_stall;
    assign o_in_stall  = r_in_valid && !w_adv;
    assign w_take      = r_in_valid && w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_code <= dmxsw_pkg::START_CODE_RST;
            for (int d = 0; d < NUM_DEVICES; d++) begin
                r_first[d] <= dmxsw_pkg::FIRST_RST;
                r_count[d] <= dmxsw_pkg::COUNT_RST;
            end
        end else if (i_cfg_valid) begin
            if (i_cfg_index == dmxsw_pkg::CFG_START_CODE) begin
                r_start_code <= i_cfg_data[dmxsw_pkg::BYTE_W-1:0];
            end
            for (int d = 0; d < NUM_DEVICES; d++) begin
                if (i_cfg_index == dmxsw_pkg::CIDX_W'(dmxsw_pkg::CFG_DEV0_FIRST + 2 * d)) begin
                    r_first[d] <= i_cfg_data;
                end
                if (i_cfg_index == dmxsw_pkg::CIDX_W'(dmxsw_pkg::CFG_DEV0_COUNT + 2 * d)) begin
                    r_count[d] <= i_cfg_data;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_in_brk  <= i_is_break;
            r_in_byte <= i_rx_byte;
        end
    end

    genvar g;
    generate
        for (g = 0; g < NUM_DEVICES; g++) begin : g_win
            dmxsw_window u_window (
                .i_slot  (r_slot),
                .i_first (r_first[g]),
                .i_count (r_count[g]),
                .o_win   (w_win[g])
            );
        end
    endgenerate

    always_comb begin
        n_slot     = r_slot;
        n_off      = r_off;
        n_out_hit  = 1'b0;
        n_out_dev  = '0;
        n_out_offs = '0;
        n_out_last = 1'b0;
        if (r_in_brk) begin
            n_slot = '0;
            n_off  = 1'b0;
        end else if (!r_off) begin
            if (r_slot == '0) begin
                if (r_in_byte == r_start_code) begin
                    n_slot = dmxsw_pkg::SLOT_W'(1);
                end else begin
                    n_off = 1'b1;
                end
            end else begin
                if (r_slot < SLOT_SAT) begin
                    n_slot = r_slot + dmxsw_pkg::SLOT_W'(1);
                end
                if (r_slot <= SLOT_MAX) begin
                    // lowest device wins
                    for (int d = NUM_DEVICES - 1; d >= 0; d--) begin
                        if (w_win[d].hit) begin
                            n_out_hit  = 1'b1;
                            n_out_dev  = dmxsw_pkg::DEV_W'(d);
                            n_out_offs = w_win[d].offset;
                            n_out_last = w_win[d].last;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot      <= '0;
            r_off       <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_take && n_out_hit;
            if (w_take) begin
                r_slot <= n_slot;
                r_off  <= n_off;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_dev  <= n_out_dev;
            r_out_offs <= n_out_offs;
            r_out_byte <= r_in_byte;
            r_out_last <= n_out_last;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_device_index = r_out_dev;
    assign o_slot_offset  = r_out_offs;
    assign o_slot_value   = r_out_byte;
    assign o_window_done  = r_out_last;

    `DSW_ASSERT(a_slot_sat, i_clk, i_rst_n, r_slot <= SLOT_SAT, "slot counter past saturation")
    `DSW_ASSERT(a_off_at_zero, i_clk, i_rst_n, r_off |-> (r_slot == '0), "offline with slot counter running")
    `DSW_ASSERT(a_stall_full, i_clk, i_rst_n, o_in_stall |-> r_in_valid, "input stalled with empty input register")
    `DSW_ASSERT(a_start_no_out, i_clk, i_rst_n, (w_take && !r_in_brk && !r_off && (r_slot == '0)) |=> !r_out_valid, "result from start code slot")

endmodule

/* bench/dmx_slot_window_checker.sv */
// Slot word checker for the DMX slot window receiver bench.
// Depends on dmxsw_pkg; watches the config, input and output channels of the block,
// predicts each routed slot word and compares it with what the block delivers.
`timescale 1ns / 1ps

module dmx_slot_window_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            o_in_stall,
    input  logic                            i_is_break,
    input  logic [dmxsw_pkg::BYTE_W-1:0]    i_rx_byte,
    input  logic                            o_out_valid,
    input  logic                            i_out_stall,
    input  logic [dmxsw_pkg::DEV_W-1:0]     o_device_index,
    input  logic [dmxsw_pkg::OFFS_W-1:0]    o_slot_offset,
    input  logic [dmxsw_pkg::BYTE_W-1:0]    o_slot_value,
    input  logic                            o_window_done,
    input  logic                            i_cfg_valid,
    input  logic                            o_cfg_ready,
    input  logic [dmxsw_pkg::CIDX_W-1:0]    i_cfg_index,
    input  logic [dmxsw_pkg::CDATA_W-1:0]   i_cfg_data,
    output int                              o_err_count,
    output int                              o_pending_count
);

    localparam int MAX_SLOT = 512;

    typedef struct packed {
        logic [dmxsw_pkg::DEV_W-1:0]  dev;
        logic [dmxsw_pkg::OFFS_W-1:0] offset;
        logic [dmxsw_pkg::BYTE_W-1:0] value;
        logic                         done;
    } t_slot_word;

    t_slot_word                   slot_words_due[$];
    logic [dmxsw_pkg::BYTE_W-1:0] start_code;
    logic [dmxsw_pkg::SLOT_W-1:0] win_first [dmxsw_pkg::DEV_MAX];
    logic [dmxsw_pkg::SLOT_W-1:0] win_count [dmxsw_pkg::DEV_MAX];
    logic [dmxsw_pkg::SLOT_W-1:0] next_slot;
    logic                         offline;
    int                           mismatches = 0;

    task automatic write_reg(input logic [dmxsw_pkg::CIDX_W-1:0] idx,
                             input logic [dmxsw_pkg::CDATA_W-1:0] data);
        if (idx == dmxsw_pkg::CFG_START_CODE)
            start_code = data[dmxsw_pkg::BYTE_W-1:0];
        for (int d = 0; d < dmxsw_pkg::DEV_MAX; d++) begin
            if (idx == dmxsw_pkg::CFG_DEV0_FIRST + dmxsw_pkg::CIDX_W'(2 * d))
                win_first[d] = data;
            else if (idx == dmxsw_pkg::CFG_DEV0_COUNT + dmxsw_pkg::CIDX_W'(2 * d))
                win_count[d] = data;
        end
    endtask

    task automatic route_word(input logic brk, input logic [dmxsw_pkg::BYTE_W-1:0] b);
        logic [dmxsw_pkg::SLOT_W:0]   slot_end;
        logic [dmxsw_pkg::SLOT_W-1:0] slot;
        t_slot_word                   w;
        if (brk) begin
            next_slot = '0;
            offline = 1'b0;
            return;
        end
        if (offline)
            return;
        if (next_slot == 0) begin
            if (b == start_code)
                next_slot = dmxsw_pkg::SLOT_W'(1);
            else
                offline = 1'b1;
            return;
        end
        slot = next_slot;
        // saturate one past the last slot
        if (next_slot < MAX_SLOT + 1)
            next_slot = next_slot + 1'b1;
        if (slot > MAX_SLOT)
            return;
        for (int d = 0; d < dmxsw_pkg::DEV_MAX; d++) begin
            slot_end = {1'b0, win_first[d]} + win_count[d];
            if (win_count[d] != 0 && slot >= win_first[d] && slot < slot_end) begin
                w.dev = dmxsw_pkg::DEV_W'(d);
                w.offset = dmxsw_pkg::OFFS_W'(slot - win_first[d]);
                w.value = b;
                w.done = (slot + 1 == slot_end);
                slot_words_due.push_back(w);
                return;
            end
        end
    endtask

    task automatic check_word();
        t_slot_word want;
        if (slot_words_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected slot word: dev %0d offset %0d value %02h done %0d",
                         o_device_index, o_slot_offset, o_slot_value, o_window_done);
            return;
        end
        want = slot_words_due.pop_front();
        if (want.dev !== o_device_index || want.offset !== o_slot_offset ||
            want.value !== o_slot_value || want.done !== o_window_done) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("slot word mismatch: expected dev %0d offset %0d value %02h done %0d",
                         want.dev, want.offset, want.value, want.done);
                $display("                    got dev %0d offset %0d value %02h done %0d",
                         o_device_index, o_slot_offset, o_slot_value, o_window_done);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start_code = dmxsw_pkg::START_CODE_RST;
            for (int d = 0; d < dmxsw_pkg::DEV_MAX; d++) begin
                win_first[d] = dmxsw_pkg::FIRST_RST;
                win_count[d] = dmxsw_pkg::COUNT_RST;
            end
            next_slot = '0;
            offline = 1'b0;
            slot_words_due.delete();
        end else begin
            if (i_cfg_valid && o_cfg_ready)
                write_reg(i_cfg_index, i_cfg_data);
            if (i_in_valid && !o_in_stall)
                route_word(i_is_break, i_rx_byte);
            if (o_out_valid && !i_out_stall)
                check_word();
        end
        o_pending_count <= slot_words_due.size();
        o_err_count <= mismatches;
    end

endmodule

/* bench/tb_top.sv */
// Top of the DMX slot window receiver bench: clock, reset, stimulus and verdict.
// Depends on dmxsw_pkg, dmx_slot_window_receiver and dmx_slot_window_checker.
`timescale 1ns / 1ps

module tb_top;

    localparam int RUN_LIMIT   = 200000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_WORDS = 50;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_in_valid = 1'b0;
    logic                           i_is_break = 1'b0;
    logic [dmxsw_pkg::BYTE_W-1:0]   i_rx_byte = '0;
    logic                           i_out_stall = 1'b0;
    logic                           i_cfg_valid = 1'b0;
    logic [dmxsw_pkg::CIDX_W-1:0]   i_cfg_index = '0;
    logic [dmxsw_pkg::CDATA_W-1:0]  i_cfg_data = '0;
    logic                           o_in_stall;
    logic                           o_out_valid;
    logic [dmxsw_pkg::DEV_W-1:0]    o_device_index;
    logic [dmxsw_pkg::OFFS_W-1:0]   o_slot_offset;
    logic [dmxsw_pkg::BYTE_W-1:0]   o_slot_value;
    logic                           o_window_done;
    logic                           o_cfg_ready;

    int                             err_count;
    int                             pending_count;
    int                             send_idle_pct = 17;
    int                             recv_idle_pct = 48;
    logic                           quiet = 1'b0;
    logic                           hold_arm = 1'b0;
    logic                           hold_done = 1'b0;
    int                             hold_left = 0;
    int                             cycles = 0;
    int                             words_sent = 0;
    logic [dmxsw_pkg::BYTE_W-1:0]   frame_start;
    logic [dmxsw_pkg::SLOT_W-1:0]   set_first [dmxsw_pkg::DEV_MAX];
    logic [dmxsw_pkg::SLOT_W-1:0]   set_count [dmxsw_pkg::DEV_MAX];

    dmx_slot_window_receiver dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_is_break     (i_is_break),
        .i_rx_byte      (i_rx_byte),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_device_index (o_device_index),
        .o_slot_offset  (o_slot_offset),
        .o_slot_value   (o_slot_value),
        .o_window_done  (o_window_done),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    dmx_slot_window_checker slot_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_is_break      (i_is_break),
        .i_rx_byte       (i_rx_byte),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_device_index  (o_device_index),
        .o_slot_offset   (o_slot_offset),
        .o_slot_value    (o_slot_value),
        .o_window_done   (o_window_done),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_err_count     (err_count),
        .o_pending_count (pending_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > RUN_LIMIT) begin
            $display("[dmx_slot_window_receiver] ERROR");
            $finish;
        end
    end

    // receiver side: random stall, one long hold once armed, none while quiet
    always @(posedge i_clk) begin
        if (hold_arm && !hold_done) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
        i_out_stall <= !quiet && (hold_left != 0 || $urandom_range(0, 99) < recv_idle_pct);
    end

    task automatic send_word(input logic brk, input logic [dmxsw_pkg::BYTE_W-1:0] b);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_is_break <= brk;
        i_rx_byte <= b;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        words_sent++;
    endtask

    task automatic cfg_put(input logic [dmxsw_pkg::CIDX_W-1:0] idx,
                           input logic [dmxsw_pkg::CDATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
    endtask

    task automatic load_setting();
        cfg_put(dmxsw_pkg::CFG_START_CODE, dmxsw_pkg::CDATA_W'(frame_start));
        for (int d = 0; d < dmxsw_pkg::DEV_MAX; d++) begin
            cfg_put(dmxsw_pkg::CFG_DEV0_FIRST + dmxsw_pkg::CIDX_W'(2 * d), set_first[d]);
            cfg_put(dmxsw_pkg::CFG_DEV0_COUNT + dmxsw_pkg::CIDX_W'(2 * d), set_count[d]);
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_setting();
        int base;
        case ($urandom_range(0, 3))
            0: frame_start = 8'h00;
            1: frame_start = 8'hFF;
            default: frame_start = dmxsw_pkg::BYTE_W'($urandom_range(0, 255));
        endcase
        base = $urandom_range(1, 6);
        for (int d = 0; d < dmxsw_pkg::DEV_MAX; d++) begin
            if ($urandom_range(0, 3) == 0) begin
                set_first[d] = dmxsw_pkg::SLOT_W'($urandom_range(1, 20));
            end else begin
                set_first[d] = dmxsw_pkg::SLOT_W'(base);
            end
            set_count[d] = dmxsw_pkg::SLOT_W'($urandom_range(0, 10));
            base = set_first[d] + set_count[d] + $urandom_range(0, 4);
        end
    endtask

    // drop valid, let the block drain without output stall, then settle
    task automatic settle();
        i_in_valid <= 1'b0;
        quiet <= 1'b1;
        @(posedge i_clk);
        @(posedge i_clk);
        while (pending_count != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        quiet <= 1'b0;
    endtask

    task automatic send_traffic();
        int kind;
        kind = $urandom_range(0, 99);
        if (kind < 80) begin
            send_word(1'b1, dmxsw_pkg::BYTE_W'($urandom));
            send_word(1'b0, frame_start);
            repeat ($urandom_range(0, 40)) send_word(1'b0, dmxsw_pkg::BYTE_W'($urandom));
        end else if (kind < 88) begin
            send_word(1'b1, dmxsw_pkg::BYTE_W'($urandom));
            send_word(1'b0, frame_start ^ dmxsw_pkg::BYTE_W'($urandom_range(1, 255)));
            repeat ($urandom_range(0, 5)) send_word(1'b0, dmxsw_pkg::BYTE_W'($urandom));
        end else if (kind < 94) begin
            repeat ($urandom_range(1, 8)) send_word(1'b0, dmxsw_pkg::BYTE_W'($urandom));
        end else begin
            repeat ($urandom_range(1, 8))
                send_word($urandom_range(0, 7) == 0, dmxsw_pkg::BYTE_W'($urandom));
        end
    endtask

    task automatic run_phase();
        random_setting();
        load_setting();
        words_sent = 0;
        while (words_sent < PHASE_WORDS)
            send_traffic();
        settle();
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // overlapping windows, a window from slot zero, start code all ones
        frame_start = 8'hFF;
        set_first[0] = 10'd1;
        set_count[0] = 10'd2;
        set_first[1] = 10'd2;
        set_count[1] = 10'd3;
        set_first[2] = 10'd0;
        set_count[2] = 10'd7;
        load_setting();
        send_word(1'b0, 8'hFF);
        send_word(1'b0, 8'h00);
        send_word(1'b1, 8'hA5);
        send_word(1'b0, 8'h00);
        send_word(1'b0, 8'hFF);
        send_word(1'b0, 8'h55);
        send_word(1'b1, 8'h00);
        send_word(1'b1, 8'hFF);
        send_word(1'b0, 8'hFF);
        send_word(1'b0, 8'hFF);
        send_word(1'b0, 8'h00);
        send_word(1'b0, 8'hAA);
        send_word(1'b0, 8'h55);
        send_word(1'b0, 8'h01);
        send_word(1'b0, 8'h80);
        send_word(1'b0, 8'h7F);
        send_word(1'b1, 8'h5A);
        settle();

        hold_arm <= 1'b1;
        run_phase();
        run_phase();
        send_idle_pct = 48;
        recv_idle_pct = 17;
        run_phase();
        run_phase();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_phase();
        run_phase();

        repeat (10) @(posedge i_clk);
        if (err_count == 0 && pending_count == 0)
            $display("[dmx_slot_window_receiver] OK");
        else
            $display("[dmx_slot_window_receiver] ERROR");
        $finish;
    end

endmodule

/* files.f */
+incdir+hdl
hdl/dmxsw_pkg.sv
hdl/dmxsw_window.sv
hdl/dmx_slot_window_receiver.sv
bench/dmx_slot_window_checker.sv
bench/tb_top.sv
